// ----- hdl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

   // Bus widths
   localparam int REQ_TDATA_W = 48;   // hue(12) + sat(16) + val(16), padded to bytes
   localparam int RSP_TDATA_W = 24;   // red, green, blue

   // Clamp limits and fixed-point ones
   localparam logic [10:0] HUE_MAX  = 11'd1535;
   localparam logic [14:0] UNIT_ONE = 15'd16384;        // 1.0 in Q2.14
   localparam logic [22:0] FRAC_ONE = 23'd4194304;      // 1.0 in Q2.14 x 256

   typedef logic [14:0] unit_type;

   // Hexcone sector, hue[10:8] after clamping
   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   // Stage 1: clamped operands
   typedef struct packed {
      sector_type  sector;
      logic [7:0]  frac;
      unit_type    sat;
      unit_type    val;
   } clamp_type;

   // Stage 2: saturation products
   typedef struct packed {
      sector_type  sector;
      unit_type    val;
      unit_type    one_minus_s;   // 2^14 - s
      logic [22:0] s_f;           // s * f
      logic [22:0] s_g;           // s * (256 - f)
   } terms_type;

   // Stage 3: products with value
   typedef struct packed {
      sector_type  sector;
      unit_type    val;
      logic [28:0] p_prod;        // v * (2^14 - s)
      logic [36:0] q_prod;        // v * (2^22 - s*f)
      logic [36:0] t_prod;        // v * (2^22 - s*(256-f))
   } prod_type;

endpackage

`default_nettype wire

// ----- hdl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Streaming HSV to 8-bit RGB pixel converter, four-stage pipeline.
// ----------------------------------------------------------------------------
// One pixel per clock: a new transaction is taken in every cycle while the
// output side keeps up. Each result passes through the four register stages
// (clamp, the saturation products, the value products, then the x255 scale
// and channel select into the output register) before it shows on
// rsp_tvalid; the first stage loads on the accepting edge. Each stage has
// its own valid bit and ready = !valid | ready_downstream, so a stall on
// rsp_tready fills bubbles first and backs up into req_tready only when all
// four stages are full.
// Hue is in 60/256-degree units and clamped to 0..1535; sat and val are
// Q2.14 and clamped to 0..16384. Levels are truncated toward zero.
// No configuration, no state between pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // hue[11:0], sat[27:12], val[43:28]
   // response stream
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   // stage handshakes
   logic      s1_valid, s1_ready;
   logic      s2_valid, s2_ready;
   logic      s3_valid, s3_ready;
   clamp_type s1_data;
   terms_type s2_data;
   prod_type  s3_data;
   logic [7:0] red, green, blue;

   // Stage 1: clamp inputs, split hue into sector and fraction
   hsv2rgb_clamp u_clamp (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .hue      (req_tdata[11:0]),
      .sat      (req_tdata[27:12]),
      .val      (req_tdata[43:28]),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_data  (s1_data)
   );

   // Stage 2: s*f and s*(1-f), plus 1-s
   hsv2rgb_terms u_terms (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   // Stage 3: multiply the p, q, t factors by value
   hsv2rgb_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_data  (s2_data),
      .dn_valid (s3_valid),
      .dn_ready (s3_ready),
      .dn_data  (s3_data)
   );

   // Stage 4: x255, truncate, map to channels by sector; drives the output
   hsv2rgb_out u_out (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s3_valid),
      .up_ready (s3_ready),
      .up_data  (s3_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .red      (red),
      .green    (green),
      .blue     (blue)
   );

   assign rsp_tdata = {blue, green, red};

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_clamp.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_clamp
// Stage 1: clamps hue, saturation and value and splits hue into sector/frac.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_clamp
   import hsv2rgb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        up_valid,
   output      logic        up_ready,
   input  wire logic [11:0] hue,
   input  wire logic [15:0] sat,
   input  wire logic [15:0] val,
   output      logic        dn_valid,
   input  wire logic        dn_ready,
   output      clamp_type   dn_data
);

   logic        valid_ff, valid_in;
   clamp_type   data_ff, data_in;
   logic [10:0] hue_c;

   assign up_ready = ~valid_ff | dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      if (hue[11]) begin
         hue_c = '0;
      end else if (hue[10:0] > HUE_MAX) begin
         hue_c = HUE_MAX;
      end else begin
         hue_c = hue[10:0];
      end

      data_in.sector = sector_type'(hue_c[10:8]);
      data_in.frac   = hue_c[7:0];

      if (sat[15]) begin
         data_in.sat = '0;
      end else if (sat[14:0] > UNIT_ONE) begin
         data_in.sat = UNIT_ONE;
      end else begin
         data_in.sat = sat[14:0];
      end

      if (val[15]) begin
         data_in.val = '0;
      end else if (val[14:0] > UNIT_ONE) begin
         data_in.val = UNIT_ONE;
      end else begin
         data_in.val = val[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_terms.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_terms
// Stage 2: saturation times hue fraction and its complement.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_terms
   import hsv2rgb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      up_valid,
   output      logic      up_ready,
   input  wire clamp_type up_data,
   output      logic      dn_valid,
   input  wire logic      dn_ready,
   output      terms_type dn_data
);

   logic      valid_ff, valid_in;
   terms_type data_ff, data_in;
   logic [8:0] frac_c;   // 256 - f

   assign up_ready = ~valid_ff | dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      frac_c              = 9'd256 - {1'b0, up_data.frac};
      data_in.sector      = up_data.sector;
      data_in.val         = up_data.val;
      data_in.one_minus_s = UNIT_ONE - up_data.sat;
      data_in.s_f         = 23'(up_data.sat) * 23'(up_data.frac);
      data_in.s_g         = 23'(up_data.sat) * 23'(frac_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_mult.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_mult
// Stage 3: scales the p, q and t factors by value.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_mult
   import hsv2rgb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      up_valid,
   output      logic      up_ready,
   input  wire terms_type up_data,
   output      logic      dn_valid,
   input  wire logic      dn_ready,
   output      prod_type  dn_data
);

   logic        valid_ff, valid_in;
   prod_type    data_ff, data_in;
   logic [22:0] q_fac, t_fac;

   assign up_ready = ~valid_ff | dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      q_fac          = FRAC_ONE - up_data.s_f;
      t_fac          = FRAC_ONE - up_data.s_g;
      data_in.sector = up_data.sector;
      data_in.val    = up_data.val;
      data_in.p_prod = 29'(up_data.val) * 29'(up_data.one_minus_s);
      data_in.q_prod = 37'(up_data.val) * 37'(q_fac);
      data_in.t_prod = 37'(up_data.val) * 37'(t_fac);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_out.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_out
// Stage 4: times 255, truncation and sector channel mapping; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_out
   import hsv2rgb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       up_valid,
   output      logic       up_ready,
   input  wire prod_type   up_data,
   output      logic       dn_valid,
   input  wire logic       dn_ready,
   output      logic [7:0] red,
   output      logic [7:0] green,
   output      logic [7:0] blue
);

   logic        valid_ff, valid_in;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [7:0]  red_in, green_in, blue_in;
   logic [22:0] v_x255;
   logic [36:0] p_x255;
   logic [44:0] q_x255, t_x255;
   logic [7:0]  lvl_v, lvl_p, lvl_q, lvl_t;

   assign up_ready = ~valid_ff | dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      // x * 255 = (x << 8) - x
      v_x255 = {up_data.val, 8'd0} - {8'd0, up_data.val};
      p_x255 = {up_data.p_prod, 8'd0} - {8'd0, up_data.p_prod};
      q_x255 = {up_data.q_prod, 8'd0} - {8'd0, up_data.q_prod};
      t_x255 = {up_data.t_prod, 8'd0} - {8'd0, up_data.t_prod};

      lvl_v = v_x255[21:14];
      lvl_p = p_x255[35:28];
      lvl_q = q_x255[43:36];
      lvl_t = t_x255[43:36];

      case (up_data.sector)
         SECTOR_0: begin
            red_in = lvl_v; green_in = lvl_t; blue_in = lvl_p;
         end
         SECTOR_1: begin
            red_in = lvl_q; green_in = lvl_v; blue_in = lvl_p;
         end
         SECTOR_2: begin
            red_in = lvl_p; green_in = lvl_v; blue_in = lvl_t;
         end
         SECTOR_3: begin
            red_in = lvl_p; green_in = lvl_q; blue_in = lvl_v;
         end
         SECTOR_4: begin
            red_in = lvl_t; green_in = lvl_p; blue_in = lvl_v;
         end
         default: begin
            red_in = lvl_v; green_in = lvl_p; blue_in = lvl_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign dn_valid = valid_ff;
   assign red      = red_ff;
   assign green    = green_ff;
   assign blue     = blue_ff;

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level assertions for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_checker
   import hsv2rgb_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam logic [2:0] PIPE_DEPTH = 3'd4;

   logic       req_acc, rsp_acc;
   logic [2:0] inflight_ff, inflight_in;

   assign req_acc = req_tvalid & req_tready;
   assign rsp_acc = rsp_tvalid & rsp_tready;

   // transactions accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_acc && !rsp_acc) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (rsp_acc && !req_acc) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // no response without a matching request
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != 3'd0)
      else $error("response with no request in flight");

   // pipeline never holds more than its stage count; the count is unknown
   // until the first reset edge
   a_depth: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(reset) |-> inflight_ff <= PIPE_DEPTH)
      else $error("more transactions in flight than stages");

   // input stalls only when every stage is full
   a_no_early_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> inflight_ff == PIPE_DEPTH)
      else $error("request stalled with free stages");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);

`default_nettype wire

// ----- verif/hsv_to_rgb_converter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Streaming test of the HSV to RGB pixel converter. Directed clamp, sector
// and grey/full-scale pixels, then random traffic with idle bursts on both
// sides, a long output hold-off that backs up the pipeline, and a final
// full-rate stretch. Every output transaction is checked field by field
// against an in-order queue of predicted levels.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
   import hsv2rgb_pkg::*;

   // fixed-point constants of the conversion
   localparam int          HUE_LAST   = 1535;
   localparam int          Q14_ONE    = 16384;
   localparam longint      Q22_ONE    = 64'd4194304;   // 1.0 scaled by 2^14 * 256
   localparam int          STALL_LIMIT = 2000;         // quiet cycles before timeout
   localparam int          DRAIN_CYCLES = 8;           // pipeline depth plus margin

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_levels_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;    // hue[11:0], sat[27:12], val[43:28], zero pad
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;    // red[7:0], green[15:8], blue[23:16]

   rgb_levels_type pixel_expect_q[$];
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   bit          tx_idle_on     = 1'b1;
   bit          rx_idle_on     = 1'b1;
   int          rx_hold_cycles = 0;     // one-shot long hold-off request for the receiver

   hsv_to_rgb_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ---------------------------------------------------------------------
   // Pixel predictor: clamp, split hue into sector and fraction, compute
   // the four hexcone levels exactly, then route them by sector.
   // ---------------------------------------------------------------------
   function automatic rgb_levels_type hsv_to_levels(input logic signed [11:0] hue,
                                                    input logic signed [15:0] sat,
                                                    input logic signed [15:0] val);
      int                hue_c;
      longint unsigned   s, v, f;
      longint unsigned   lvl_v, lvl_p, lvl_q, lvl_t;
      logic [10:0]       hue_bits;
      sector_type        sector;
      rgb_levels_type    px;
      hue_c = (hue < 0) ? 0 : (hue > HUE_LAST) ? HUE_LAST : int'(hue);
      s     = (sat < 0) ? 0 : (sat > Q14_ONE) ? Q14_ONE : longint'(sat);
      v     = (val < 0) ? 0 : (val > Q14_ONE) ? Q14_ONE : longint'(val);
      hue_bits = hue_c[10:0];
      sector   = sector_type'(hue_bits[10:8]);
      f        = hue_bits[7:0];
      lvl_v = (v * 255) >> 14;
      lvl_p = (v * (Q14_ONE - s) * 255) >> 28;
      lvl_q = (v * (Q22_ONE - s * f) * 255) >> 36;
      lvl_t = (v * (Q22_ONE - s * (256 - f)) * 255) >> 36;
      case (sector)
         SECTOR_0: px = '{lvl_v[7:0], lvl_t[7:0], lvl_p[7:0]};
         SECTOR_1: px = '{lvl_q[7:0], lvl_v[7:0], lvl_p[7:0]};
         SECTOR_2: px = '{lvl_p[7:0], lvl_v[7:0], lvl_t[7:0]};
         SECTOR_3: px = '{lvl_p[7:0], lvl_q[7:0], lvl_v[7:0]};
         SECTOR_4: px = '{lvl_t[7:0], lvl_p[7:0], lvl_v[7:0]};
         default:  px = '{lvl_v[7:0], lvl_p[7:0], lvl_q[7:0]};
      endcase
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: at each rising edge, check an output transaction against
   // the oldest prediction, then queue the prediction for an input one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rgb_levels_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = pixel_expect_q.pop_front();
               if (rsp_tdata[7:0] !== want.red)
                  report_mismatch($sformatf("red %0d, want %0d", rsp_tdata[7:0], want.red));
               if (rsp_tdata[15:8] !== want.green)
                  report_mismatch($sformatf("green %0d, want %0d",
                                            rsp_tdata[15:8], want.green));
               if (rsp_tdata[23:16] !== want.blue)
                  report_mismatch($sformatf("blue %0d, want %0d",
                                            rsp_tdata[23:16], want.blue));
            end
         end
         if (req_tvalid && req_tready)
            pixel_expect_q.push_back(hsv_to_levels(req_tdata[11:0], req_tdata[27:12],
                                                   req_tdata[43:28]));
      end
   end

   // Watchdog: a run of cycles with no transaction on either side is a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver: random idle bursts, or one long hold-off when a test asks.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold_cycles) @(negedge clock);
            rx_hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one pixel, optionally after an idle burst, and wait for acceptance.
   task automatic send_pixel(input logic [11:0] hue, input logic [15:0] sat,
                             input logic [15:0] val);
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, val, sat, hue};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly legal Q2.14 values, with clamp edges and raw 16-bit noise mixed in.
   function automatic logic [15:0] random_q14();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 16'($urandom_range(0, Q14_ONE));
      if (pick == 12) return 16'd0;
      if (pick == 13) return 16'(Q14_ONE);
      if (pick == 14) return 16'($urandom_range(Q14_ONE - 64, Q14_ONE));
      return 16'($urandom);
   endfunction

   function automatic logic [11:0] random_hue();
      if ($urandom_range(0, 9) < 7) return 12'($urandom_range(0, HUE_LAST));
      return 12'($urandom);
   endfunction

   // clamping of out-of-range fields, including the field extremes
   task automatic test_clamp_limits();
      send_pixel(-12'sd2048, -16'sd32768, -16'sd32768);
      send_pixel(12'sd2047, 16'sd32767, 16'sd32767);
      send_pixel(-12'sd1, 16'sd16384, 16'sd16384);
      send_pixel(12'sd1535, 16'sd16384, 16'sd16384);   // last unit of sector 5
      send_pixel(12'sd1536, 16'sd16385, 16'sd16385);   // just over every limit
      send_pixel(12'sd0, 16'sd16384, 16'sd16384);
      send_pixel(12'sd100, -16'sd1, 16'sd12000);
      send_pixel(12'sd700, 16'sd9000, -16'sd1);
      send_pixel(12'sd255, 16'sd0, 16'sd0);
   endtask

   // every sector with a mid fraction, plus the ends of a few sectors
   task automatic test_sectors();
      for (int k = 0; k < 6; k++)
         send_pixel(12'(k * 256 + 90), 16'sd12345, 16'sd15000);
      send_pixel(12'd511, 16'sd16000, 16'sd16384);
      send_pixel(12'd768, 16'sd16000, 16'sd16384);
      send_pixel(12'd1279, 16'sd8192, 16'sd10000);
   endtask

   // grey pixels at zero saturation, and full-scale levels at 255
   task automatic test_grey_and_full();
      send_pixel(12'd777, 16'sd0, 16'sd9999);
      send_pixel(12'd1200, 16'sd0, 16'sd16384);
      send_pixel(12'd300, 16'sd16384, 16'sd16384);
      send_pixel(12'd1023, 16'sd16384, 16'sd16384);
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_pixel(random_hue(), random_q14(), random_q14());
   endtask

   // receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_output_hold();
      tx_idle_on     = 1'b0;
      rx_hold_cycles = 80;
      repeat (40) send_pixel(random_hue(), random_q14(), random_q14());
      tx_idle_on     = 1'b1;
   endtask

   // back-to-back traffic with no idling at all
   task automatic test_full_rate(input int count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (count) send_pixel(random_hue(), random_q14(), random_q14());
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_clamp_limits();
      test_sectors();
      test_grey_and_full();
      test_random_traffic(560);
      test_output_hold();
      test_full_rate(180);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pixel_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pixel_expect_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pixel_expect_q.size()));

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
